// File: hdl/cdbf_pkg.sv
package cdbf_pkg;

   // number of m values tried by a search, 1..16
   localparam int M_CHOICES = 8;
   localparam int N_CHOICES = 8;

   localparam int RATE_W = 32;
   localparam int DSR_W  = 8;

   // pipelined divider: quotient bits resolved per stage
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = RATE_W / DIV_BITS;

   // divide by ten through a reciprocal multiply, exact for any 32-bit value
   localparam logic [RATE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                RECIP_SHIFT = 35;

   // comparison tree over the m lanes
   localparam int TREE_LVL = (M_CHOICES <= 2) ? 1 : $clog2(M_CHOICES);
   localparam int TREE_W   = 1 << TREE_LVL;

   // stage map
   localparam int PD_FIRST   = 0;
   localparam int MUL_STG    = PD_FIRST + DIV_STAGES;
   localparam int LANE_FIRST = MUL_STG + 1;
   localparam int LANE_LAST  = LANE_FIRST + DIV_STAGES - 1;
   localparam int SEL_STG    = LANE_LAST + 1;
   localparam int TREE_FIRST = SEL_STG + 1;
   localparam int OUT_STG    = TREE_FIRST + TREE_LVL;
   localparam int NSTG       = OUT_STG + 1;

   localparam logic CMD_SEARCH = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   localparam logic CSR_PRE_DIV  = 1'b0;
   localparam logic CSR_M_OFFSET = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [RATE_W-1:0] target;
      logic [6:0]        word;
   } sb_type;

   typedef struct packed {
      logic              ok;
      logic [RATE_W-1:0] rate;
      logic [3:0]        m;
      logic [2:0]        n;
   } cand_type;

endpackage

// File: hdl/cdbf_divider.sv
module cdbf_divider (
   input  logic                                clock,
   input  logic [cdbf_pkg::DIV_STAGES-1:0]     en,
   input  logic [cdbf_pkg::RATE_W-1:0]         dividend,
   input  logic [cdbf_pkg::DSR_W-1:0]          divisor,
   output logic [cdbf_pkg::RATE_W-1:0]         quotient
);

   // restoring division; dq shifts dividend bits out and quotient bits in
   logic [cdbf_pkg::RATE_W-1:0] dq_ff  [cdbf_pkg::DIV_STAGES];
   logic [cdbf_pkg::DSR_W-1:0]  rem_ff [cdbf_pkg::DIV_STAGES];
   logic [cdbf_pkg::DSR_W-1:0]  dsr_ff [cdbf_pkg::DIV_STAGES];

   logic [cdbf_pkg::RATE_W-1:0] dq_in  [cdbf_pkg::DIV_STAGES];
   logic [cdbf_pkg::DSR_W-1:0]  rem_in [cdbf_pkg::DIV_STAGES];
   logic [cdbf_pkg::DSR_W-1:0]  dsr_in [cdbf_pkg::DIV_STAGES];

   always_comb begin
      logic [cdbf_pkg::RATE_W-1:0] dq;
      logic [cdbf_pkg::DSR_W-1:0]  rem;
      logic [cdbf_pkg::DSR_W-1:0]  d;
      logic [cdbf_pkg::DSR_W:0]    t;
      for (int s = 0; s < cdbf_pkg::DIV_STAGES; s++) begin
         if (s == 0) begin
            dq  = dividend;
            rem = '0;
            d   = divisor;
         end else begin
            dq  = dq_ff[s-1];
            rem = rem_ff[s-1];
            d   = dsr_ff[s-1];
         end
         for (int b = 0; b < cdbf_pkg::DIV_BITS; b++) begin
            t  = {rem, dq[cdbf_pkg::RATE_W-1]};
            dq = {dq[cdbf_pkg::RATE_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
               t     = t - {1'b0, d};
               dq[0] = 1'b1;
            end
            rem = t[cdbf_pkg::DSR_W-1:0];
         end
         dq_in[s]  = dq;
         rem_in[s] = rem;
         dsr_in[s] = d;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < cdbf_pkg::DIV_STAGES; s++) begin
         if (en[s]) begin
            dq_ff[s]  <= dq_in[s];
            rem_ff[s] <= rem_in[s];
            dsr_ff[s] <= dsr_in[s];
         end
      end
   end

   assign quotient = dq_ff[cdbf_pkg::DIV_STAGES-1];

endmodule

// File: hdl/clock_divider_best_fit_search.sv
// Clock divider best-fit search. Search (command 0) tries every m below
// M_CHOICES and n 0..7, rate = ((source/pre_divider)/10 >> n)/(m+offset), and
// returns the highest rate not above the target (first pair on a tie), or
// zeros when none fits. Decode (command 1) returns the rate of divider_word.
// Fully pipelined: one request per cycle until a stalled output fills the
// pipe; requests pass two 8-stage dividers (4 quotient bits per stage),
// the reciprocal multiply for the divide by ten, the n select and the
// comparison tree over the m lanes. Any stage bubble is filled while the
// output is stalled. Registers must only be written while the pipe is empty.
module clock_divider_best_fit_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_target_rate,
   input  logic [31:0] req_source_rate,
   input  logic [6:0]  req_divider_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_rate,
   output logic [3:0]  rsp_chosen_m,
   output logic [2:0]  rsp_chosen_n,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   localparam int NS = cdbf_pkg::NSTG;
   localparam int TW = cdbf_pkg::TREE_W;
   localparam int TL = cdbf_pkg::TREE_LVL;
   localparam int MC = cdbf_pkg::M_CHOICES;

   logic [7:0] pre_div_ff;
   logic [3:0] m_off_ff;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;
   cdbf_pkg::sb_type sb_ff [NS];
   cdbf_pkg::sb_type req_sb;

   logic [7:0]  pd_eff;
   logic [31:0] pd_q;
   logic [63:0] prod_ff;
   logic [31:0] base;
   logic [31:0] lane_q [MC];

   cdbf_pkg::cand_type leaf_in  [TW];
   cdbf_pkg::cand_type leaf_ff  [TW];
   cdbf_pkg::cand_type tree_in  [TL][TW/2];
   cdbf_pkg::cand_type tree_ff  [TL][TW/2];
   cdbf_pkg::cand_type out_ff;

   function automatic cdbf_pkg::cand_type pick(cdbf_pkg::cand_type a,
                                               cdbf_pkg::cand_type b);
      // left wins ties: it was tried first
      if (b.ok && (!a.ok || b.rate > a.rate)) return b;
      return a;
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_div_ff <= 8'd2;
         m_off_ff   <= 4'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            cdbf_pkg::CSR_PRE_DIV:  pre_div_ff <= csr_write_data;
            cdbf_pkg::CSR_M_OFFSET: m_off_ff   <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // stage i loads when empty or when its content moves on
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int i = NS-2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NS-1];
   assign req_sb    = '{cmd: req_command, target: req_target_rate, word: req_divider_word};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (en[i]) v_ff[i] <= (i == 0) ? req_valid : v_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (en[i]) sb_ff[i] <= (i == 0) ? req_sb : sb_ff[(i == 0) ? 0 : i-1];
      end
   end

   // source / pre_divider
   assign pd_eff = (pre_div_ff == 8'd0) ? 8'd1 : pre_div_ff;

   cdbf_divider u_pre_div (
      .clock    (clock),
      .en       (en[cdbf_pkg::PD_FIRST +: cdbf_pkg::DIV_STAGES]),
      .dividend (req_source_rate),
      .divisor  (pd_eff),
      .quotient (pd_q)
   );

   // divide by ten
   always_ff @(posedge clock) begin
      if (en[cdbf_pkg::MUL_STG]) prod_ff <= {32'd0, pd_q} * {32'd0, cdbf_pkg::RECIP_TEN};
   end

   assign base = 32'(prod_ff >> cdbf_pkg::RECIP_SHIFT);

   // one divider per m; floor(floor(b/2^n)/d) = floor(b/d) >> n
   for (genvar g = 0; g < MC; g++) begin : g_lane
      logic [3:0] lane_m;
      logic [4:0] sum;
      logic [4:0] dsr;
      assign lane_m = (sb_ff[cdbf_pkg::MUL_STG].cmd == cdbf_pkg::CMD_DECODE) ?
                      sb_ff[cdbf_pkg::MUL_STG].word[6:3] : 4'(g);
      assign sum = {1'b0, lane_m} + {1'b0, m_off_ff};
      assign dsr = (sum == 5'd0) ? 5'd1 : sum;

      cdbf_divider u_lane_div (
         .clock    (clock),
         .en       (en[cdbf_pkg::LANE_FIRST +: cdbf_pkg::DIV_STAGES]),
         .dividend (base),
         .divisor  ({3'd0, dsr}),
         .quotient (lane_q[g])
      );
   end

   // per lane: smallest n whose rate fits gives the lane's best; decode uses lane 0 only
   always_comb begin
      cdbf_pkg::sb_type sb;
      logic [31:0] r;
      sb = sb_ff[cdbf_pkg::LANE_LAST];
      for (int j = 0; j < TW; j++) begin
         leaf_in[j] = '{ok: 1'b0, rate: '0, m: 4'(j), n: '0};
      end
      for (int j = 0; j < MC; j++) begin
         for (int n = cdbf_pkg::N_CHOICES-1; n >= 0; n--) begin
            r = lane_q[j] >> n;
            if (r <= sb.target) begin
               leaf_in[j].ok   = (r != 32'd0);
               leaf_in[j].rate = r;
               leaf_in[j].n    = 3'(n);
            end
         end
      end
      if (sb.cmd == cdbf_pkg::CMD_DECODE) begin
         for (int j = 1; j < TW; j++) leaf_in[j].ok = 1'b0;
         leaf_in[0] = '{ok: 1'b1, rate: lane_q[0] >> sb.word[2:0],
                        m: sb.word[6:3], n: sb.word[2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[cdbf_pkg::SEL_STG]) leaf_ff <= leaf_in;
   end

   always_comb begin
      tree_in = '{default: '{default: '0}};
      for (int l = 0; l < TL; l++) begin
         for (int k = 0; k < (TW >> (l+1)); k++) begin
            if (l == 0) tree_in[l][k] = pick(leaf_ff[2*k], leaf_ff[2*k+1]);
            else        tree_in[l][k] = pick(tree_ff[(l == 0) ? 0 : l-1][2*k],
                                             tree_ff[(l == 0) ? 0 : l-1][2*k+1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < TL; l++) begin
         if (en[cdbf_pkg::TREE_FIRST + l]) tree_ff[l] <= tree_in[l];
      end
   end

   always_ff @(posedge clock) begin
      if (en[cdbf_pkg::OUT_STG]) begin
         if (tree_ff[TL-1][0].ok) out_ff <= tree_ff[TL-1][0];
         else                     out_ff <= '{ok: 1'b0, rate: '0, m: '0, n: '0};
      end
   end

   assign rsp_result_rate = out_ff.rate;
   assign rsp_chosen_m    = out_ff.m;
   assign rsp_chosen_n    = out_ff.n;

`ifndef SYNTHESIS
   a_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sb_ff[NS-1].cmd == cdbf_pkg::CMD_SEARCH |->
      rsp_result_rate <= sb_ff[NS-1].target)
      else $error("search result above target");

   a_nofit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sb_ff[NS-1].cmd == cdbf_pkg::CMD_SEARCH && rsp_result_rate == 32'd0 |->
      rsp_chosen_m == 4'd0 && rsp_chosen_n == 3'd0)
      else $error("empty search returned a divider pair");

   a_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid && v_ff == '0)
      else $error("pipeline not empty after reset");
`endif

endmodule
